/* rtl/osa_pkg.sv */
// Package with shared constants and types for the OSA edit distance block.
package osa_pkg;

	localparam int MAX_LEN = 128;
	localparam int IDX_W   = $clog2(MAX_LEN + 1);
	localparam int QA_W    = $clog2(MAX_LEN);
	localparam int SYM_W   = 8;
	localparam int DIST_W  = 8;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;

	localparam logic KIND_QUERY     = 1'b0;
	localparam logic KIND_CANDIDATE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

/* rtl/osa_edit_distance.sv */
// Top level of the optimal-string-alignment edit distance block.
//
// The block takes items on the slave stream (s_*) and returns distances on
// the master stream (m_*). s_tuser tells a query character (0) from a
// candidate character (1); s_tdata carries the character and the start
// flag; s_tlast marks the final character of a candidate word.
// A query transfer writes one character into the query memory and leaves
// s_tready high; characters beyond MAX_LEN are dropped and flagged.
// A candidate transfer computes one column of the distance table, one cell
// per cycle through a single shared cell unit, and keeps the slave side
// busy until row n is done, where n is the stored query length (up to
// MAX_LEN). With s_tlast set, a done state waits for a free output
// register; the distance then appears and s_tready returns in the same cycle.
// The result sits in an output register: the block accepts further items
// while it waits, and only a second result blocks behind a stalled
// receiver until the first one is taken.
// Reset clears the query length, the overflow flag, the candidate state and
// the output valid; the memories hold no defined contents until written.
module osa_edit_distance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [osa_pkg::S_DATA_W-1:0]  s_tdata,   // symbol[7:0], first[8], zero[15:9]
	input  logic                          s_tuser,   // kind
	input  logic                          s_tlast,   // last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [osa_pkg::M_DATA_W-1:0]  m_tdata,   // distance[7:0]
	output logic                          m_tuser    // truncated
);
	import osa_pkg::*;

	state_t state_q, state_d;

	// Control state, reset to the values of an empty query.
	logic [IDX_W-1:0]  qlen_q;
	logic              ovf_q;
	logic [DIST_W-1:0] cand_len_q;
	logic [SYM_W-1:0]  prev_char_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              m_tvalid_q;

	// Per-candidate working registers.
	logic [SYM_W-1:0]  sym_q;
	logic              last_q;
	logic              init_q;
	logic              trans_q;
	logic [DIST_W-1:0] cl_q;
	logic [DIST_W-1:0] cur_q;
	logic [DIST_W-1:0] pv_a_q;
	logic [DIST_W-1:0] p2_a_q;
	logic [DIST_W-1:0] p2_b_q;
	logic [SYM_W-1:0]  qa_q;
	logic [DIST_W-1:0] dist_q;
	logic              trunc_q;

	// Memories and their registered read data.
	logic [SYM_W-1:0]  qmem  [MAX_LEN];
	logic [DIST_W-1:0] colp  [MAX_LEN+1];
	logic [DIST_W-1:0] colp2 [MAX_LEN+1];
	logic [SYM_W-1:0]  q_rd_q;
	logic [DIST_W-1:0] colp_rd_q;
	logic [DIST_W-1:0] colp2_rd_q;

	logic              s_xfer;
	logic              in_first;
	logic [SYM_W-1:0]  in_sym;
	logic [IDX_W-1:0]  qlen_eff;
	logic              q_we;
	logic [QA_W-1:0]   q_raddr;
	logic [IDX_W-1:0]  col_raddr;
	logic              col_we;
	logic              at_end;
	logic              out_free;
	logic              load_out;
	logic [DIST_W-1:0] prev_k;
	logic [DIST_W-1:0] diag;
	logic [DIST_W-1:0] best;
	logic [DIST_W-1:0] cur;

	function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
		return (v == {DIST_W{1'b1}}) ? v : v + DIST_W'(1);
	endfunction

	function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	assign in_sym   = s_tdata[SYM_W-1:0];
	assign in_first = s_tdata[SYM_W];
	assign s_xfer   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign at_end   = (cnt_q == qlen_q);

	// A new query restarts the fill position.
	assign qlen_eff = in_first ? '0 : qlen_q;
	assign q_we     = s_xfer && (s_tuser == KIND_QUERY) && (qlen_eff < IDX_W'(MAX_LEN));

	// Reads run one index ahead of the cell being computed.
	always_comb begin
		if (state_q == ST_RUN) begin
			q_raddr   = cnt_q[QA_W-1:0];
			col_raddr = at_end ? cnt_q : cnt_q + IDX_W'(1);
		end else begin
			q_raddr   = '0;
			col_raddr = '0;
		end
	end

	assign col_we = (state_q == ST_RUN);

	// Shared cell unit: one cell of the current column per cycle. A fresh
	// word sees the previous column as the row numbers themselves.
	always_comb begin
		if (init_q) begin
			prev_k = (cnt_q > IDX_W'(255)) ? 8'd255 : DIST_W'(cnt_q);
		end else begin
			prev_k = colp_rd_q;
		end
		diag = (q_rd_q != sym_q) ? sat_inc(pv_a_q) : pv_a_q;
		best = min2(min2(sat_inc(cur_q), sat_inc(prev_k)), diag);
		if (cnt_q >= IDX_W'(2) && trans_q && q_rd_q == prev_char_q && qa_q == sym_q) begin
			best = min2(best, sat_inc(p2_b_q));
		end
		if (cnt_q == '0) begin
			cur = sat_inc(cl_q);
		end else begin
			cur = best;
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[qlen_eff[QA_W-1:0]] <= in_sym;
		end
		q_rd_q <= qmem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			colp[cnt_q]  <= cur;
			colp2[cnt_q] <= prev_k;
		end
		colp_rd_q  <= colp[col_raddr];
		colp2_rd_q <= colp2[col_raddr];
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer && s_tuser == KIND_CANDIDATE) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (at_end) begin
					state_d = last_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q      <= '0;
			ovf_q       <= 1'b0;
			cand_len_q  <= '0;
			prev_char_q <= '0;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (s_xfer && s_tuser == KIND_QUERY) begin
				cand_len_q <= '0;
				if (qlen_eff < IDX_W'(MAX_LEN)) begin
					qlen_q <= qlen_eff + IDX_W'(1);
					ovf_q  <= in_first ? 1'b0 : ovf_q;
				end else begin
					qlen_q <= qlen_eff;
					ovf_q  <= 1'b1;
				end
			end
			if (s_xfer && s_tuser == KIND_CANDIDATE) begin
				cnt_q <= '0;
			end else if (state_q == ST_RUN) begin
				if (at_end) begin
					prev_char_q <= sym_q;
					cand_len_q  <= sat_inc(cl_q);
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser == KIND_CANDIDATE) begin
			sym_q   <= in_sym;
			last_q  <= s_tlast;
			cl_q    <= in_first ? '0 : cand_len_q;
			init_q  <= in_first || (cand_len_q == '0);
			trans_q <= !in_first && (cand_len_q != '0);
		end
		if (state_q == ST_RUN) begin
			cur_q  <= cur;
			pv_a_q <= prev_k;
			p2_a_q <= colp2_rd_q;
			p2_b_q <= p2_a_q;
			qa_q   <= q_rd_q;
		end
		// The overflow flag is captured with the distance, since later query
		// transfers may change it while the result waits.
		if (load_out) begin
			dist_q  <= cur_q;
			trunc_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = dist_q;
	assign m_tuser  = trunc_q;

endmodule

/* rtl/osa_checker.sv */
// Port-level checker for the OSA edit distance block, bound to the top level.
module osa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [osa_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [osa_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          m_tuser
);
	import osa_pkg::*;

	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	// A candidate character occupies the cell unit, so s_tready drops after its transfer.
	a_cand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser == KIND_CANDIDATE |=> !s_tready)
		else $error("ready right after a candidate transfer");

	// A query character is stored without dropping s_tready.
	a_query_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser == KIND_QUERY |=> s_tready)
		else $error("not ready after a query transfer");

	// A query character never produces a result.
	a_query_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser == KIND_QUERY && (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("result after a query transfer");

	// s_tlast and s_tdata are only sampled on transfers; keep them observed.
	logic unused_ok;
	assign unused_ok = s_tlast ^ (^s_tdata);

endmodule

bind osa_edit_distance osa_checker u_osa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/sv/tb_osa_edit_distance.sv */
// Self-checking testbench for the OSA edit distance block: streamed query and candidate words.
module tb_osa_edit_distance;
	import osa_pkg::*;

	localparam int ITEM_TARGET    = 1450;
	localparam int TAIL_ITEMS     = 150;   // the last items go through with no idling
	localparam int HOLD_AFTER     = 300;   // transfers taken before the long receiver hold
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 300;   // idle run after the last result is taken
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SAT            = 255;
	localparam int PAD_W          = S_DATA_W - SYM_W - 1;

	typedef struct packed {
		logic             kind;
		logic [SYM_W-1:0] symbol;
		logic             first;
		logic             last;
	} char_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              truncated;
	} distance_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;   // symbol[7:0], first[8], zero[15:9]
	logic                s_tuser  = 1'b0; // kind
	logic                s_tlast  = 1'b0; // last
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;         // distance[7:0]
	logic                m_tuser;         // truncated

	osa_edit_distance dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	char_item_t pending_items[$];
	distance_t  expected_distances[$];
	logic [7:0] gen_query[$];   // the query as the stimulus side loaded it
	logic [7:0] word_buf[$];

	// Transfer handed from the driver to the checker in the cycle after it is taken.
	char_item_t taken_item  = '0;
	logic       taken_valid = 1'b0;
	int         items_taken = 0;
	logic       quiet_tail  = 1'b0;
	int         mismatches  = 0;
	int         stall_cycles = 0;

	// Shadow of the block's distance table state.
	logic [7:0] q_mem [MAX_LEN];
	int         q_len    = 0;
	logic       q_over   = 1'b0;
	logic [7:0] col_last  [MAX_LEN+1];
	logic [7:0] col_older [MAX_LEN+1];
	logic [7:0] prev_sym = '0;
	int         word_len = 0;

	function automatic int sat8(input int v);
		return (v > SAT) ? SAT : v;
	endfunction

	// Applies one transfer to the shadow state and queues the distance it yields, if any.
	task automatic advance_distance_table(input char_item_t it);
		logic [7:0] fresh [MAX_LEN+1];
		int n;
		int diag;
		int best;
		distance_t res;
		if (it.kind == KIND_QUERY) begin
			if (it.first) begin
				q_len  = 0;
				q_over = 1'b0;
			end
			if (q_len < MAX_LEN) begin
				q_mem[q_len] = it.symbol;
				q_len++;
			end else begin
				q_over = 1'b1;
			end
			word_len = 0;
		end else begin
			if (it.first)
				word_len = 0;
			n = q_len;
			// A fresh word starts from the all-deletions column.
			if (word_len == 0)
				for (int i = 0; i <= n; i++)
					col_last[i] = 8'(i);
			fresh[0] = 8'(sat8(word_len + 1));
			for (int i = 1; i <= n; i++) begin
				diag = int'(col_last[i-1]) + ((q_mem[i-1] != it.symbol) ? 1 : 0);
				best = int'(fresh[i-1]) + 1;
				if (int'(col_last[i]) + 1 < best)
					best = int'(col_last[i]) + 1;
				if (diag < best)
					best = diag;
				// Adjacent transposition of the last two candidate characters.
				if (i >= 2 && word_len >= 1 && q_mem[i-1] == prev_sym &&
						q_mem[i-2] == it.symbol && int'(col_older[i-2]) + 1 < best)
					best = int'(col_older[i-2]) + 1;
				fresh[i] = 8'(sat8(best));
			end
			for (int i = 0; i <= n; i++) begin
				col_older[i] = col_last[i];
				col_last[i]  = fresh[i];
			end
			prev_sym = it.symbol;
			if (word_len < SAT)
				word_len++;
			if (it.last) begin
				res.distance  = fresh[n];
				res.truncated = q_over;
				expected_distances.push_back(res);
			end
		end
	endtask

	task automatic queue_char(input logic kind, input logic [7:0] sym, input logic first,
			input logic last);
		char_item_t it;
		it.kind   = kind;
		it.symbol = sym;
		it.first  = first;
		it.last   = last;
		pending_items.push_back(it);
	endtask

	// A narrow alphabet makes matches and transpositions common.
	function automatic logic [7:0] pick_symbol(input bit wide);
		return wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 100));
	endfunction

	task automatic load_query(input int len, input bit wide);
		logic [7:0] sym;
		gen_query.delete();
		for (int k = 0; k < len; k++) begin
			sym = pick_symbol(wide);
			gen_query.push_back(sym);
			// A last mark on a query character now and then must be ignored.
			queue_char(KIND_QUERY, sym, k == 0, $urandom_range(0, 29) == 0);
		end
	endtask

	// Builds a candidate word: at times a lightly edited copy of the query, else random.
	task automatic build_word(input bit wide);
		int len;
		int pos;
		int span;
		logic [7:0] t;
		word_buf.delete();
		span = (gen_query.size() > 40) ? 3 : 1;
		if (gen_query.size() > 0 && $urandom_range(0, span) == 0) begin
			word_buf = gen_query;
			repeat ($urandom_range(1, 2)) begin
				pos = $urandom_range(0, word_buf.size() - 1);
				case ($urandom_range(0, 3))
					0: begin
						if (pos + 1 < word_buf.size()) begin
							t = word_buf[pos];
							word_buf[pos] = word_buf[pos+1];
							word_buf[pos+1] = t;
						end
					end
					1: word_buf[pos] = pick_symbol(wide);
					2: begin
						if (word_buf.size() > 1)
							word_buf.delete(pos);
					end
					default: word_buf.insert(pos, pick_symbol(wide));
				endcase
			end
		end else begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			repeat (len)
				word_buf.push_back(pick_symbol(wide));
		end
	endtask

	task automatic send_word(input bit mark_first, input bit mark_last);
		for (int k = 0; k < word_buf.size(); k++)
			queue_char(KIND_CANDIDATE, word_buf[k], mark_first && k == 0,
				mark_last && k == word_buf.size() - 1);
	endtask

	task automatic fill_stimulus();
		bit wide;
		int roll;
		int len;
		logic [7:0] sym;
		// Empty query right after reset, and a word with no start mark.
		queue_char(KIND_CANDIDATE, "a", 1'b0, 1'b0);
		queue_char(KIND_CANDIDATE, "b", 1'b0, 1'b1);
		queue_char(KIND_CANDIDATE, 8'hFF, 1'b1, 1'b1);
		// Query "ab" whose second character carries an ignored last mark.
		queue_char(KIND_QUERY, "a", 1'b1, 1'b0);
		queue_char(KIND_QUERY, "b", 1'b0, 1'b1);
		// Transposed word straight after the query, again without a start mark.
		queue_char(KIND_CANDIDATE, "b", 1'b0, 1'b0);
		queue_char(KIND_CANDIDATE, "a", 1'b0, 1'b1);
		queue_char(KIND_CANDIDATE, "a", 1'b1, 1'b0);
		queue_char(KIND_CANDIDATE, "b", 1'b0, 1'b1);
		// A query character abandons the word in progress and extends the query.
		queue_char(KIND_CANDIDATE, "x", 1'b1, 1'b0);
		queue_char(KIND_QUERY, "c", 1'b0, 1'b0);
		queue_char(KIND_CANDIDATE, "c", 1'b0, 1'b1);
		// Extreme symbol values, swapped.
		queue_char(KIND_QUERY, 8'h00, 1'b1, 1'b0);
		queue_char(KIND_QUERY, 8'hFF, 1'b0, 1'b0);
		queue_char(KIND_CANDIDATE, 8'hFF, 1'b1, 1'b0);
		queue_char(KIND_CANDIDATE, 8'h00, 1'b0, 1'b1);
		queue_char(KIND_CANDIDATE, 8'h55, 1'b1, 1'b0);
		queue_char(KIND_CANDIDATE, 8'hAA, 1'b0, 1'b0);
		queue_char(KIND_CANDIDATE, 8'h00, 1'b0, 1'b1);
		gen_query = '{8'h00, 8'hFF};

		// One query that certainly runs past the store, with a few words against it.
		load_query($urandom_range(MAX_LEN + 1, MAX_LEN + 8), 1'b1);
		repeat (4) begin
			build_word(1'b1);
			send_word(1'b1, 1'b1);
		end

		while (pending_items.size() < ITEM_TARGET) begin
			wide = $urandom_range(0, 2) == 0;
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				len = $urandom_range(0, 99);
				if (len < 88)
					len = $urandom_range(1, 10);
				else if (len < 96)
					len = $urandom_range(11, 40);
				else
					len = $urandom_range(MAX_LEN - 2, MAX_LEN + 12);
				load_query(len, wide);
			end else if (roll < 16) begin
				// Query characters with no start mark append to the stored query.
				repeat ($urandom_range(1, 3)) begin
					sym = pick_symbol(wide);
					gen_query.push_back(sym);
					queue_char(KIND_QUERY, sym, 1'b0, 1'b0);
				end
			end else if (roll < 17 && gen_query.size() <= 12) begin
				// Long word: drives the word length and the distance into saturation.
				word_buf.delete();
				repeat ($urandom_range(270, 300))
					word_buf.push_back(pick_symbol(1'b1));
				send_word(1'b1, 1'b1);
			end else begin
				build_word(wide);
				send_word($urandom_range(0, 11) != 0, $urandom_range(0, 11) != 0);
			end
		end
	endtask

	// Sender: offers the head of the queue, with random gaps between transfers.
	int   tx_gap   = 0;
	int   tx_phase = 0;
	bit   tx_calm  = 1'b0;
	logic tx_took;
	logic tx_offer;
	char_item_t tx_head;

	always @(posedge clk) begin
		if (arst_n) begin
			tx_took = s_tvalid && s_tready;
			if (tx_took)
				taken_item <= pending_items.pop_front();
			taken_valid <= tx_took;
			items_taken <= items_taken + (tx_took ? 1 : 0);
			if (tx_phase == 0) begin
				tx_phase = $urandom_range(50, 400);
				tx_calm  = $urandom_range(0, 2) == 0;
			end else begin
				tx_phase--;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				tx_offer = 1'b0;
			end else if ((tx_took || !s_tvalid) && !tx_calm &&
					pending_items.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
				tx_gap   = $urandom_range(0, 12);
				tx_offer = 1'b0;
			end else begin
				tx_offer = pending_items.size() > 0;
			end
			s_tvalid <= tx_offer;
			if (tx_offer) begin
				tx_head = pending_items[0];
				s_tuser <= tx_head.kind;
				s_tdata <= {{PAD_W{1'b0}}, tx_head.first, tx_head.symbol};
				s_tlast <= tx_head.last;
			end
			quiet_tail <= pending_items.size() <= TAIL_ITEMS;
		end
	end

	// Receiver and checker: predicts last cycle's transfer first, then checks the result.
	int   rx_gap    = 0;
	int   rx_phase  = 0;
	bit   rx_calm   = 1'b0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	logic rx_ready;
	distance_t rx_exp;

	always @(posedge clk) begin
		if (arst_n) begin
			if (taken_valid)
				advance_distance_table(taken_item);
			if (m_tvalid && m_tready) begin
				if (expected_distances.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected distance %0d truncated %0b", m_tdata, m_tuser);
					mismatches++;
				end else begin
					rx_exp = expected_distances.pop_front();
					if (rx_exp.distance !== m_tdata || rx_exp.truncated !== m_tuser) begin
						if (mismatches < 10)
							$display("distance mismatch: expected %0d truncated %0b, got %0d truncated %0b",
								rx_exp.distance, rx_exp.truncated, m_tdata, m_tuser);
						mismatches++;
					end
				end
			end
			// One long hold-off so that a second result backs up into the input.
			if (!hold_done && items_taken >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (rx_phase == 0) begin
				rx_phase = $urandom_range(50, 400);
				rx_calm  = $urandom_range(0, 2) == 0;
			end else begin
				rx_phase--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rx_ready = 1'b0;
			end else if (!rx_calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
				rx_gap   = $urandom_range(0, 12);
				rx_ready = 1'b0;
			end else begin
				rx_ready = 1'b1;
			end
			m_tready <= rx_ready;
		end
	end

	// Ends the run when neither side has moved for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL osa_edit_distance");
			$finish;
		end
	end

	initial begin
		fill_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_items.size() != 0 || taken_valid || expected_distances.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_distances.size() == 0)
			$display("PASS osa_edit_distance");
		else
			$display("FAIL osa_edit_distance");
		$finish;
	end

endmodule
